// ----- design/ostt_pkg.sv -----
// Shared types and constants for the one-shot timer table.
package ostt_pkg;

  localparam int unsigned TicksW      = 32;
  localparam int unsigned OwnerW      = 8;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned IntervalW   = 10;
  localparam int unsigned SlotIdxW    = 4;
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned CntW        = 5;

  localparam logic [IntervalW-1:0] TickIntervalReset = 10'd10;

  typedef enum logic [1:0] {
    FuncTick = 2'd0,
    FuncSet  = 2'd1,
    FuncRead = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    KindExpired  = 3'd0,
    KindNoExpiry = 3'd1,
    KindSetOk    = 3'd2,
    KindSetFull  = 3'd3,
    KindTime     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFinish
  } state_e;

  typedef struct packed {
    kind_e                kind;
    logic [OwnerW-1:0]    thread_id;
    logic [SlotIdxW-1:0]  slot_index;
    logic [TimeW-1:0]     time_value;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_owner;
  } mem_ctrl_t;

endpackage

// ----- design/one_shot_timer_table_unit.sv -----
// Top level of the one-shot timer table: item sequencer, slot walk and result register.
// A tick or set walks the slot memory one slot per cycle while no output stall holds the walk; a tick
// walks every slot, a set stops after the lowest free slot, and a read does not walk at all.
// The walk pace is set by the single read port of the slot memory; an output stall on a second
// expiry holds the walk. Reset clears control state and the per-slot valid bits,
// so every slot is free at once.
module one_shot_timer_table_unit import ostt_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IntervalW-1:0] cfg_wdata_i,      // tick_interval
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [39:0]          s_axis_tdata_i,   // timer_ticks[31:0], owner_thread[39:32]
  input  logic [1:0]           s_axis_tuser_i,   // func[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [47:0]          m_axis_tdata_o,   // thread_id[7:0], slot_index[11:8],
                                                 // time_value[43:12], zero fill[47:44]
  output logic [2:0]           m_axis_tuser_o,   // kind[2:0]
  output logic                 m_axis_tlast_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PtrW = $clog2(SLOTS + 1);
  localparam logic [PtrW-1:0] SlotsCount = PtrW'(SLOTS);

  state_e               state_q, state_d;
  logic [1:0]           func_q;
  logic [TicksW-1:0]    ticks_q;
  logic [OwnerW-1:0]    owner_q;
  logic [IntervalW-1:0] interval_q;
  logic [TimeW-1:0]     elapsed_q;
  logic [PtrW-1:0]      rd_ptr_q;
  logic                 s1_valid_q;
  logic [IdxW-1:0]      s1_idx_q;
  logic                 found_q;
  logic [IdxW-1:0]      found_idx_q;
  logic [CntW-1:0]      exp_cnt_q;
  logic                 pend_valid_q;
  logic [IdxW-1:0]      pend_idx_q;
  logic [OwnerW-1:0]    pend_owner_q;
  logic [SLOTS-1:0]     slot_valid_q;
  result_t              out_q;
  logic                 out_valid_q;

  mem_ctrl_t            mem_ctrl;
  logic [TicksW-1:0]    rd_ticks;
  logic [OwnerW-1:0]    rd_owner;
  logic [TicksW-1:0]    wr_ticks;
  logic [TicksW-1:0]    cur_ticks;
  logic                 in_acc;
  logic                 out_free;
  logic                 walk_op;
  logic                 s1_busy;
  logic                 s1_expire;
  logic                 s1_claim;
  logic                 s1_go;
  logic                 adv;
  logic                 issue;
  logic                 walk_done;
  logic                 push_walk;
  logic                 push_fin;
  logic                 fin_has_result;
  result_t              res_walk;
  result_t              res_fin;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign walk_op  = (func_q == FuncTick) || (func_q == FuncSet);

  assign cur_ticks = slot_valid_q[s1_idx_q] ? rd_ticks : '0;
  assign s1_busy   = cur_ticks != '0;
  assign s1_expire = (func_q == FuncTick) && (cur_ticks == TicksW'(1))
                     && (exp_cnt_q < CntW'(ResultLimit));
  assign s1_claim  = (func_q == FuncSet) && !found_q && !s1_busy;
  assign s1_go     = !(s1_expire && pend_valid_q) || out_free;
  assign adv       = !s1_valid_q || s1_go;
  assign issue     = (state_q == StWalk) && walk_op && !found_q
                     && (rd_ptr_q != SlotsCount) && adv;
  assign walk_done = (!walk_op || found_q || (rd_ptr_q == SlotsCount)) && !s1_valid_q;

  assign push_walk      = (state_q == StWalk) && s1_valid_q && s1_expire && pend_valid_q
                          && out_free;
  assign fin_has_result = walk_op || (func_q == FuncRead);
  assign push_fin       = (state_q == StFinish) && fin_has_result && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (walk_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!fin_has_result || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Memory control and result formation.
  always_comb begin
    mem_ctrl.rd_en    = issue;
    mem_ctrl.wr_en    = (state_q == StWalk) && s1_valid_q && s1_go
                        && (s1_claim || ((func_q == FuncTick) && s1_busy));
    mem_ctrl.wr_owner = s1_claim;
    wr_ticks          = s1_claim ? ticks_q : cur_ticks - TicksW'(1);

    res_walk            = '0;
    res_walk.kind       = KindExpired;
    res_walk.thread_id  = pend_owner_q;
    res_walk.slot_index = SlotIdxW'(pend_idx_q);

    res_fin      = '0;
    res_fin.last = 1'b1;
    case (func_q)
      FuncTick: begin
        if (pend_valid_q) begin
          res_fin.kind       = KindExpired;
          res_fin.thread_id  = pend_owner_q;
          res_fin.slot_index = SlotIdxW'(pend_idx_q);
        end else begin
          res_fin.kind = KindNoExpiry;
        end
      end
      FuncSet: begin
        if (found_q) begin
          res_fin.kind       = KindSetOk;
          res_fin.slot_index = SlotIdxW'(found_idx_q);
        end else begin
          res_fin.kind = KindSetFull;
        end
      end
      FuncRead: begin
        res_fin.kind       = KindTime;
        res_fin.time_value = elapsed_q;
      end
      default: res_fin.kind = KindNoExpiry;
    endcase
  end

  ostt_slot_mem #(
    .SLOTS (SLOTS),
    .IdxW  (IdxW)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .ctrl_i     (mem_ctrl),
    .rd_addr_i  (rd_ptr_q[IdxW-1:0]),
    .wr_addr_i  (s1_idx_q),
    .wr_ticks_i (wr_ticks),
    .wr_owner_i (owner_q),
    .rd_ticks_o (rd_ticks),
    .rd_owner_o (rd_owner)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      interval_q   <= TickIntervalReset;
      elapsed_q    <= '0;
      rd_ptr_q     <= '0;
      s1_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      exp_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        rd_ptr_q     <= '0;
        found_q      <= 1'b0;
        exp_cnt_q    <= '0;
        pend_valid_q <= 1'b0;
        if (s_axis_tuser_i == FuncTick) begin
          elapsed_q <= elapsed_q + TimeW'(interval_q);
        end
      end
      if (issue) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if ((state_q == StWalk) && adv) begin
        s1_valid_q <= issue;
      end
      if ((state_q == StWalk) && s1_valid_q && s1_go) begin
        if (s1_claim) begin
          found_q                <= 1'b1;
          slot_valid_q[s1_idx_q] <= 1'b1;
        end
        if (s1_expire) begin
          exp_cnt_q    <= exp_cnt_q + CntW'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (push_walk || push_fin) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q  <= s_axis_tuser_i;
      ticks_q <= (s_axis_tdata_i[31:0] == '0) ? TicksW'(1) : s_axis_tdata_i[31:0];
      owner_q <= s_axis_tdata_i[39:32];
    end
    if (issue) begin
      s1_idx_q <= rd_ptr_q[IdxW-1:0];
    end
    if ((state_q == StWalk) && s1_valid_q && s1_go) begin
      if (s1_claim) begin
        found_idx_q <= s1_idx_q;
      end
      if (s1_expire) begin
        pend_idx_q   <= s1_idx_q;
        pend_owner_q <= rd_owner;
      end
    end
    if (push_walk) begin
      out_q <= res_walk;
    end else if (push_fin) begin
      out_q <= res_fin;
    end
  end

  assign s_axis_tready_o = state_q == StIdle;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q.time_value, out_q.slot_index, out_q.thread_id};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule

// ----- design/ostt_slot_mem.sv -----
// Slot memories for remaining tick counts and owner ids, with a registered read port.
module ostt_slot_mem import ostt_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned IdxW  = 4
) (
  input  logic              clk_i,
  input  mem_ctrl_t         ctrl_i,
  input  logic [IdxW-1:0]   rd_addr_i,
  input  logic [IdxW-1:0]   wr_addr_i,
  input  logic [TicksW-1:0] wr_ticks_i,
  input  logic [OwnerW-1:0] wr_owner_i,
  output logic [TicksW-1:0] rd_ticks_o,
  output logic [OwnerW-1:0] rd_owner_o
);

  logic [TicksW-1:0] ticks_mem [SLOTS];
  logic [OwnerW-1:0] owner_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      ticks_mem[wr_addr_i] <= wr_ticks_i;
    end
    if (ctrl_i.wr_en && ctrl_i.wr_owner) begin
      owner_mem[wr_addr_i] <= wr_owner_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_ticks_o <= ticks_mem[rd_addr_i];
      rd_owner_o <= owner_mem[rd_addr_i];
    end
  end

endmodule

// ----- design/ostt_checker.sv -----
// Port-level assertions for the one-shot timer table, bound to the top level.
module ostt_checker import ostt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [1:0]           s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [47:0]          m_axis_tdata_o,
  input logic [2:0]           m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  logic       s_acc;
  logic       m_acc;
  logic [1:0] open_q;
  logic [1:0] open_d;

  assign s_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc  = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    open_d = open_q;
    if (s_acc && ((s_axis_tuser_i == FuncTick) || (s_axis_tuser_i == FuncSet)
                  || (s_axis_tuser_i == FuncRead))) begin
      open_d = open_d + 2'd1;
    end
    if (m_acc && m_axis_tlast_o) begin
      open_d = open_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  // A stalled output beat holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // Only expiry reports may be followed by further results of the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != KindExpired) |-> m_axis_tlast_o)
    else $error("non-expiry result without last");

  // No result appears without an item that still owes one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> open_q != 2'd0)
    else $error("result without an open item");

endmodule

bind one_shot_timer_table_unit ostt_checker u_ostt_checker (.*);

// ----- bench/tb.sv -----
// Self-checking testbench for the one-shot timer table unit.
module tb;
  import ostt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots        = 16;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 300;
  localparam logic [1:0]  FuncReserved = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [IntervalW-1:0] cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [39:0]          s_axis_tdata_i = '0;   // timer_ticks[31:0], owner_thread[39:32]
  logic [1:0]           s_axis_tuser_i = '0;   // func[1:0]
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [47:0]          m_axis_tdata_o;        // thread_id[7:0], slot_index[11:8],
                                               // time_value[43:12], zero fill[47:44]
  logic [2:0]           m_axis_tuser_o;        // kind[2:0]
  logic                 m_axis_tlast_o;

  one_shot_timer_table_unit #(.SLOTS(Slots)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [TicksW-1:0]    slot_ticks [Slots];
  logic [OwnerW-1:0]    slot_thread [Slots];
  logic [TimeW-1:0]     elapsed_ms;
  logic [IntervalW-1:0] interval_ms;
  result_t              pending_results [$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned expiries_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned error_count = 0;

  function automatic int unsigned free_slot_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < Slots; i++) begin
      if (slot_ticks[i] == '0) n++;
    end
    return n;
  endfunction

  task automatic push_result(input kind_e kind, input logic [OwnerW-1:0] thread,
                             input logic [SlotIdxW-1:0] slot, input logic [TimeW-1:0] tval,
                             input logic last);
    result_t r;
    r.kind = kind;
    r.thread_id = thread;
    r.slot_index = slot;
    r.time_value = tval;
    r.last = last;
    pending_results.push_back(r);
  endtask

  task automatic advance_timers(input logic [1:0] func, input logic [TicksW-1:0] ticks,
                                input logic [OwnerW-1:0] owner);
    logic [Slots-1:0] fired;
    int unsigned      n_fired;
    int unsigned      k;
    int               free_idx;
    fired = '0;
    n_fired = 0;
    k = 0;
    free_idx = -1;
    case (func)
      FuncTick: begin
        elapsed_ms = elapsed_ms + TimeW'(interval_ms);
        for (int i = 0; i < Slots; i++) begin
          if (slot_ticks[i] != '0) begin
            slot_ticks[i] = slot_ticks[i] - TicksW'(1);
            if (slot_ticks[i] == '0 && n_fired < ResultLimit) begin
              fired[i] = 1'b1;
              n_fired++;
            end
          end
        end
        if (n_fired == 0) begin
          push_result(KindNoExpiry, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < Slots; i++) begin
            if (fired[i]) begin
              k++;
              push_result(KindExpired, slot_thread[i], SlotIdxW'(i), '0, k == n_fired);
            end
          end
        end
      end
      FuncSet: begin
        if (ticks == '0) ticks = TicksW'(1);
        for (int i = Slots - 1; i >= 0; i--) begin
          if (slot_ticks[i] == '0) free_idx = i;
        end
        if (free_idx >= 0) begin
          slot_ticks[free_idx] = ticks;
          slot_thread[free_idx] = owner;
          push_result(KindSetOk, '0, SlotIdxW'(free_idx), '0, 1'b1);
        end else begin
          push_result(KindSetFull, '0, '0, '0, 1'b1);
        end
      end
      FuncRead: begin
        push_result(KindTime, '0, '0, elapsed_ms, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [1:0] func, input logic [TicksW-1:0] ticks,
                           input logic [OwnerW-1:0] owner);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {owner, ticks};
    s_axis_tuser_i <= func;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    advance_timers(func, ticks, owner);
    items_sent++;
  endtask

  task automatic release_sender();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [IntervalW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    interval_ms = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(FuncRead, '0, '0);
    send_item(FuncTick, '0, '0);
    send_item(FuncReserved, '1, '1);
    send_item(FuncSet, 32'd0, 8'hFF);
    send_item(FuncSet, 32'd1, 8'h00);
    for (int i = 2; i < Slots; i++) begin
      send_item(FuncSet, 32'd1, OwnerW'(i * 17));
    end
    send_item(FuncSet, 32'hFFFF_FFFF, 8'h5A);
    send_item(FuncTick, '0, '0);
    // This timer holds slot zero for the rest of the run.
    send_item(FuncSet, 32'hFFFF_FFFF, 8'h00);
    send_item(FuncRead, '0, '0);
    release_sender();
  endtask

  task automatic test_random_mix(input int unsigned n_items, input int unsigned idle_pct,
                                 input int unsigned stall_pct);
    int unsigned       counted;
    int unsigned       roll;
    logic [TicksW-1:0] ticks;
    counted = 0;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    while (counted < n_items) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        send_item(FuncTick, $urandom, OwnerW'($urandom));
        counted++;
      end else if (roll < 78) begin
        if (free_slot_count() > 4 && $urandom_range(39) == 0) ticks = $urandom;
        else ticks = $urandom_range(6);
        send_item(FuncSet, ticks, OwnerW'($urandom_range(255)));
        counted++;
      end else if (roll < 95) begin
        send_item(FuncRead, $urandom, OwnerW'($urandom));
        counted++;
      end else begin
        send_item(FuncReserved, $urandom, OwnerW'($urandom));
      end
    end
    release_sender();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_output_hold();
    hold_left = HoldCycles;
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_item(FuncSet, $urandom_range(3), OwnerW'($urandom_range(255)));
      else send_item(FuncTick, '0, '0);
    end
    release_sender();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  result_t observed;
  result_t wanted;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      observed.kind = kind_e'(m_axis_tuser_o);
      observed.thread_id = m_axis_tdata_o[7:0];
      observed.slot_index = m_axis_tdata_o[11:8];
      observed.time_value = m_axis_tdata_o[43:12];
      observed.last = m_axis_tlast_o;
      results_checked++;
      if (observed.kind == KindExpired) expiries_seen++;
      if (observed.kind == KindSetFull) rejects_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("tb: unexpected beat kind=%0d thread=%0d slot=%0d time=%0d last=%0b",
                   observed.kind, observed.thread_id, observed.slot_index,
                   observed.time_value, observed.last);
        end
      end else begin
        wanted = pending_results.pop_front();
        if (observed.kind !== wanted.kind || observed.thread_id !== wanted.thread_id ||
            observed.slot_index !== wanted.slot_index ||
            observed.time_value !== wanted.time_value || observed.last !== wanted.last ||
            m_axis_tdata_o[47:44] !== 4'h0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("tb: mismatch at %0t: expected kind=%0d thread=%0d slot=%0d time=%0d last=%0b",
                     $realtime, wanted.kind, wanted.thread_id, wanted.slot_index,
                     wanted.time_value, wanted.last);
            $display("tb:   got kind=%0d thread=%0d slot=%0d time=%0d last=%0b fill=%h",
                     observed.kind, observed.thread_id, observed.slot_index,
                     observed.time_value, observed.last, m_axis_tdata_o[47:44]);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      slot_ticks[i] = '0;
      slot_thread[i] = '0;
    end
    elapsed_ms = '0;
    interval_ms = TickIntervalReset;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    write_interval(10'd1);
    test_random_mix(22, 0, 0);
    write_interval(10'd1023);
    test_random_mix(22, 77, 0);
    write_interval(10'd0);
    test_random_mix(22, 0, 77);
    write_interval(10'd1000);
    test_random_mix(22, 26, 26);
    test_output_hold();
    drain_results();

    $display("tb: %0d items sent, %0d results checked, %0d expiries, %0d full-table rejects",
             items_sent, results_checked, expiries_seen, rejects_seen);
    $display("tb: intervals 10, 1, 1023, 0 and 1000 ms, four idle mixes, one long output hold");
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- one_shot_timer_table_unit.f -----
design/ostt_pkg.sv
design/ostt_slot_mem.sv
design/one_shot_timer_table_unit.sv
design/ostt_checker.sv
bench/tb.sv
